>>> hdl/vmmio_pkg.sv
// ----------------------------------------------------------------------------
// virtio-mmio register block package
// Shared item types, offsets and controller command types.
// ----------------------------------------------------------------------------
package vmmio_pkg;

    typedef struct packed {
        logic [1:0]  op;
        logic [11:0] reg_offset;
        logic [31:0] write_value;
        logic [2:0]  access_bytes;
    } vmmio_item_t;

    typedef struct packed {
        logic [31:0] read_value;
        logic        read_hit;
        logic        write_applied;
        logic        notify_valid;
        logic [15:0] notify_queue;
        logic        notify_bad_queue;
        logic        irq_level;
        logic        irq_changed;
    } vmmio_result_t;

    localparam logic [1:0] OP_READ     = 2'd0;
    localparam logic [1:0] OP_WRITE    = 2'd1;
    localparam logic [1:0] OP_COMPLETE = 2'd2;

    localparam logic [2:0] CFG_DEV_FEATURES = 3'd0;
    localparam logic [2:0] CFG_MAGIC        = 3'd1;
    localparam logic [2:0] CFG_VERSION      = 3'd2;
    localparam logic [2:0] CFG_DEVICE_ID    = 3'd3;
    localparam logic [2:0] CFG_VENDOR_ID    = 3'd4;
    localparam logic [2:0] CFG_CAPACITY     = 3'd5;

    localparam logic [11:0] OFF_MAGIC       = 12'h000;
    localparam logic [11:0] OFF_VERSION     = 12'h004;
    localparam logic [11:0] OFF_DEVICE_ID   = 12'h008;
    localparam logic [11:0] OFF_VENDOR_ID   = 12'h00c;
    localparam logic [11:0] OFF_DEV_FEAT    = 12'h010;
    localparam logic [11:0] OFF_DEV_FSEL    = 12'h014;
    localparam logic [11:0] OFF_DRV_FEAT    = 12'h020;
    localparam logic [11:0] OFF_DRV_FSEL    = 12'h024;
    localparam logic [11:0] OFF_QSEL        = 12'h030;
    localparam logic [11:0] OFF_QMAX        = 12'h034;
    localparam logic [11:0] OFF_QSIZE       = 12'h038;
    localparam logic [11:0] OFF_QREADY      = 12'h044;
    localparam logic [11:0] OFF_NOTIFY      = 12'h050;
    localparam logic [11:0] OFF_IRQ_STATUS  = 12'h060;
    localparam logic [11:0] OFF_IRQ_ACK     = 12'h064;
    localparam logic [11:0] OFF_STATUS      = 12'h070;
    localparam logic [11:0] OFF_DESC_LO     = 12'h080;
    localparam logic [11:0] OFF_DESC_HI     = 12'h084;
    localparam logic [11:0] OFF_AVAIL_LO    = 12'h090;
    localparam logic [11:0] OFF_AVAIL_HI    = 12'h094;
    localparam logic [11:0] OFF_USED_LO     = 12'h0a0;
    localparam logic [11:0] OFF_USED_HI     = 12'h0a4;
    localparam logic [11:0] CFG_SPACE_BASE  = 12'h100;

    localparam logic [31:0] DEV_STATUS_FEAT_BIT = 32'h8;
    localparam logic [31:0] IRQ_ACK_MASK        = 32'h3;

    // One-hot controller states.
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DONE = 2'b10
    } vmmio_state_t;

    // Controller to datapath commands.
    typedef struct packed {
        logic execute;
    } vmmio_cmd_t;

    // Byte mask for an access length; lengths of 0 or above 4 count as 4.
    function automatic logic [31:0] byte_mask(input logic [2:0] n);
        logic [31:0] m;
        begin
            case (n)
                3'd1:    m = 32'h0000_00ff;
                3'd2:    m = 32'h0000_ffff;
                3'd3:    m = 32'h00ff_ffff;
                default: m = 32'hffff_ffff;
            endcase
            return m;
        end
    endfunction

endpackage

>>> hdl/virtio_mmio_register_block.sv
// ----------------------------------------------------------------------------
// virtio-mmio register block
// Register file of a virtio-mmio block device transport.
// ----------------------------------------------------------------------------
// Usage: drive item with a bus read, a bus write or a back-end completion
// and raise start. The transaction is taken at a clock edge where start is
// high and busy is low; at that same edge the datapath decodes the offset,
// updates the registers and registers the outcome. In the following cycle
// busy and done are high and result carries the outcome; no transaction is
// taken while done is high. The result is shown for exactly one cycle; the
// receiver cannot stall it. Identity and capacity values are loaded
// through the cfg port (cfg_we, cfg_index, cfg_data); the user must load
// them only while no transaction is in flight; the block does not check
// it. Reset clears all driver-visible registers and drops the interrupt
// line; identity registers return to their defaults.
// ----------------------------------------------------------------------------
module virtio_mmio_register_block
    import vmmio_pkg::*;
#(
    parameter int NUM_QUEUES     = 1,
    parameter int QUEUE_SIZE_MAX = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  vmmio_item_t   item,
    output logic          done,
    output vmmio_result_t result,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data
);

    vmmio_cmd_t cmd;

    // Sequencer: an idle state that accepts and executes, one that shows the result.
    vmmio_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    // Register file and decode.
    vmmio_dp #(
        .NUM_QUEUES     (NUM_QUEUES),
        .QUEUE_SIZE_MAX (QUEUE_SIZE_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res       (result)
    );

endmodule

>>> hdl/vmmio_ctrl.sv
// ----------------------------------------------------------------------------
// virtio-mmio controller
// Takes a command, has the datapath execute it and raises the result strobe.
// ----------------------------------------------------------------------------
module vmmio_ctrl
    import vmmio_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    output logic       done,
    output vmmio_cmd_t cmd
);

    vmmio_state_t state_reg;
    vmmio_state_t state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.execute = 1'b1;
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = (state_reg == ST_DONE);

endmodule

>>> hdl/vmmio_dp.sv
// ----------------------------------------------------------------------------
// virtio-mmio datapath
// Register file, read mux and write decode for one accepted transaction.
// ----------------------------------------------------------------------------
module vmmio_dp
    import vmmio_pkg::*;
#(
    parameter int NUM_QUEUES     = 1,
    parameter int QUEUE_SIZE_MAX = 256
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  vmmio_cmd_t    cmd,
    input  vmmio_item_t   item,
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_data,
    output vmmio_result_t res
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

    logic [63:0] dev_feat_reg, cap_reg;
    logic [31:0] magic_reg, version_reg, dev_id_reg, vendor_reg;

    logic [31:0] dev_fsel_reg, drv_fsel_reg, qsel_reg, irq_status_reg, status_reg;
    logic [63:0] drv_feat_reg;
    logic        irq_line_reg;
    logic [15:0] qsize_reg  [NUM_QUEUES];
    logic        qready_reg [NUM_QUEUES];
    logic [63:0] desc_reg   [NUM_QUEUES];
    logic [63:0] avail_reg  [NUM_QUEUES];
    logic [63:0] used_reg   [NUM_QUEUES];

    vmmio_result_t res_reg, res_next;

    logic [31:0] mask, v, wmask16, stat_val, stat_set, cap_word;
    logic        qok;
    logic [QW-1:0] q;
    logic [3:0]  cfg_end;
    logic [7:0]  cap_off;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_feat_reg <= '0;
            magic_reg    <= 32'h7472_6976;
            version_reg  <= 32'd2;
            dev_id_reg   <= 32'd2;
            vendor_reg   <= '0;
            cap_reg      <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_DEV_FEATURES: dev_feat_reg <= cfg_data;
                CFG_MAGIC:        magic_reg    <= cfg_data[31:0];
                CFG_VERSION:      version_reg  <= cfg_data[31:0];
                CFG_DEVICE_ID:    dev_id_reg   <= cfg_data[31:0];
                CFG_VENDOR_ID:    vendor_reg   <= cfg_data[31:0];
                CFG_CAPACITY:     cap_reg      <= cfg_data;
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        mask     = byte_mask(item.access_bytes);
        v        = item.write_value & mask;
        wmask16  = mask & 32'h0000_ffff;
        qok      = (qsel_reg < 32'(NUM_QUEUES));
        q        = qok ? qsel_reg[QW-1:0] : '0;
        stat_set = v & ~status_reg;
        if (stat_set == '0)
            stat_val = '0;
        else if (stat_set == DEV_STATUS_FEAT_BIT && (drv_feat_reg & ~dev_feat_reg) != '0)
            stat_val = v & ~DEV_STATUS_FEAT_BIT;
        else
            stat_val = v;
        cap_off  = item.reg_offset[7:0];
        cfg_end  = 4'(cap_off[2:0]) + 4'(mask == 32'hffff_ffff ? 3'd4 : item.access_bytes);
        cap_word = 32'(cap_reg >> {cap_off[2:0], 3'b000}) & mask;
    end

    // Result of the transaction being accepted, taken from the state before it.
    always_comb
    begin
        res_next = '0;
        res_next.irq_level = irq_line_reg;
        case (item.op)
            OP_READ:
            begin
                if (item.reg_offset >= CFG_SPACE_BASE)
                begin
                    if (item.reg_offset[11:8] == 4'h1 && cap_off[7:3] == '0
                        && cfg_end <= 4'd8)
                    begin
                        res_next.read_value = cap_word;
                        res_next.read_hit   = 1'b1;
                    end
                end
                else
                begin
                    res_next.read_hit = 1'b1;
                    case (item.reg_offset)
                        OFF_MAGIC:      res_next.read_value = magic_reg;
                        OFF_VERSION:    res_next.read_value = version_reg;
                        OFF_DEVICE_ID:  res_next.read_value = dev_id_reg;
                        OFF_VENDOR_ID:  res_next.read_value = vendor_reg;
                        OFF_DEV_FEAT:
                            res_next.read_value = (dev_fsel_reg == 32'd0) ? dev_feat_reg[31:0]
                                : (dev_fsel_reg == 32'd1) ? dev_feat_reg[63:32] : '0;
                        OFF_QMAX:
                            res_next.read_value = qok ? 32'(QUEUE_SIZE_MAX) : '0;
                        OFF_QREADY:
                            res_next.read_value = qok ? 32'(qready_reg[q]) : 32'hffff_ffff;
                        OFF_IRQ_STATUS: res_next.read_value = irq_status_reg;
                        OFF_STATUS:     res_next.read_value = status_reg;
                        default:        res_next.read_hit   = 1'b0;
                    endcase
                end
            end
            OP_WRITE:
            begin
                case (item.reg_offset)
                    OFF_DEV_FSEL, OFF_DRV_FSEL, OFF_QSEL, OFF_STATUS:
                        res_next.write_applied = 1'b1;
                    OFF_DRV_FEAT:
                        res_next.write_applied = (drv_fsel_reg < 32'd2);
                    OFF_QSIZE, OFF_QREADY, OFF_DESC_LO, OFF_DESC_HI,
                    OFF_AVAIL_LO, OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI:
                        res_next.write_applied = qok;
                    OFF_NOTIFY:
                    begin
                        res_next.notify_valid     = 1'b1;
                        res_next.notify_queue     = v[15:0];
                        res_next.notify_bad_queue = (32'(v[15:0]) >= 32'(NUM_QUEUES));
                    end
                    OFF_IRQ_ACK:
                    begin
                        if ((v & IRQ_ACK_MASK) != '0)
                        begin
                            res_next.irq_changed   = irq_line_reg;
                            res_next.irq_level     = 1'b0;
                            res_next.write_applied = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            OP_COMPLETE:
            begin
                res_next.irq_changed = ~irq_line_reg;
                res_next.irq_level   = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_fsel_reg   <= '0;
            drv_fsel_reg   <= '0;
            qsel_reg       <= '0;
            drv_feat_reg   <= '0;
            irq_status_reg <= '0;
            status_reg     <= '0;
            irq_line_reg   <= 1'b0;
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                qsize_reg[i]  <= '0;
                qready_reg[i] <= 1'b0;
                desc_reg[i]   <= '0;
                avail_reg[i]  <= '0;
                used_reg[i]   <= '0;
            end
            res_reg <= '0;
        end
        else if (cmd.execute)
        begin
            res_reg <= res_next;
            case (item.op)
                OP_WRITE:
                begin
                    case (item.reg_offset)
                        OFF_DEV_FSEL:
                            dev_fsel_reg <= (dev_fsel_reg & ~mask) | v;
                        OFF_DRV_FEAT:
                        begin
                            if (drv_fsel_reg == 32'd0)
                                drv_feat_reg[31:0] <= (drv_feat_reg[31:0] & ~mask) | v;
                            else if (drv_fsel_reg == 32'd1)
                                drv_feat_reg[63:32] <= (drv_feat_reg[63:32] & ~mask) | v;
                        end
                        OFF_DRV_FSEL:
                            drv_fsel_reg <= (drv_fsel_reg & ~mask) | v;
                        OFF_QSEL:
                            qsel_reg <= (qsel_reg & ~mask) | v;
                        OFF_QSIZE:
                        begin
                            if (qok)
                                qsize_reg[q] <= (qsize_reg[q] & ~wmask16[15:0]) | v[15:0];
                        end
                        OFF_QREADY:
                        begin
                            if (qok)
                                qready_reg[q] <= v[0];
                        end
                        OFF_IRQ_ACK:
                        begin
                            if ((v & IRQ_ACK_MASK) != '0)
                            begin
                                irq_line_reg   <= 1'b0;
                                irq_status_reg <= irq_status_reg & ~v;
                            end
                        end
                        OFF_STATUS:
                            status_reg <= (status_reg & ~mask) | (stat_val & mask);
                        OFF_DESC_LO, OFF_DESC_HI:
                        begin
                            if (qok)
                            begin
                                if (item.reg_offset[2])
                                    desc_reg[q][63:32] <= (desc_reg[q][63:32] & ~mask) | v;
                                else
                                    desc_reg[q][31:0] <= (desc_reg[q][31:0] & ~mask) | v;
                            end
                        end
                        OFF_AVAIL_LO, OFF_AVAIL_HI:
                        begin
                            if (qok)
                            begin
                                if (item.reg_offset[2])
                                    avail_reg[q][63:32] <= (avail_reg[q][63:32] & ~mask) | v;
                                else
                                    avail_reg[q][31:0] <= (avail_reg[q][31:0] & ~mask) | v;
                            end
                        end
                        OFF_USED_LO, OFF_USED_HI:
                        begin
                            if (qok)
                            begin
                                if (item.reg_offset[2])
                                    used_reg[q][63:32] <= (used_reg[q][63:32] & ~mask) | v;
                                else
                                    used_reg[q][31:0] <= (used_reg[q][31:0] & ~mask) | v;
                            end
                        end
                        default: ;
                    endcase
                end
                OP_COMPLETE:
                begin
                    irq_status_reg <= irq_status_reg | 32'd1;
                    irq_line_reg   <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign res = res_reg;

endmodule

>>> hdl/vmmio_checker.sv
// ----------------------------------------------------------------------------
// virtio-mmio port checker
// Port-level properties of the register block.
// ----------------------------------------------------------------------------
module vmmio_checker
    import vmmio_pkg::*;
(
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input logic          done,
    input vmmio_result_t result
);

    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> done) else $error("no result after accept");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("result repeated");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("result while idle");

    a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.read_hit && result.write_applied))
        else $error("read and write both reported");

endmodule

bind virtio_mmio_register_block vmmio_checker u_vmmio_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

>>> test/virtio_mmio_register_block_tb.sv
// ----------------------------------------------------------------------------
// virtio-mmio register block testbench
// Drives bus reads, bus writes and back-end completions into the register
// block, predicts every result with a behavioral model of the register file,
// and compares each result field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module virtio_mmio_register_block_tb;
    import vmmio_pkg::*;

    localparam int NQ       = 1;
    localparam int QMAX     = 256;
    localparam int LIMIT    = 400000;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    vmmio_item_t   item;
    logic          done;
    vmmio_result_t result;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [63:0]   cfg_data;

    virtio_mmio_register_block #(.NUM_QUEUES(NQ), .QUEUE_SIZE_MAX(QMAX)) uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item(item),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Shadow copy of the device configuration.
    logic [63:0] m_dev_feat;
    logic [31:0] m_magic, m_version, m_dev_id, m_vendor;
    logic [63:0] m_capacity;

    // Shadow copy of the driver-visible register state.
    logic [31:0] m_dev_fsel, m_drv_fsel, m_qsel, m_irq_status, m_status;
    logic [63:0] m_drv_feat, m_desc, m_avail, m_used;
    logic [15:0] m_qsize;
    logic        m_qready, m_irq;

    vmmio_result_t pending_results[$];
    int            mismatches;
    int            cycles;

    function automatic logic [31:0] len_mask(input int n);
        return (n >= 4) ? 32'hffff_ffff : ((32'd1 << (8 * n)) - 32'd1);
    endfunction

    function automatic logic [31:0] merge_bytes(input logic [31:0] old,
                                                input logic [31:0] v, input int n);
        logic [31:0] m;
        m = len_mask(n);
        return (old & ~m) | (v & m);
    endfunction

    function automatic logic [63:0] merge_word(input logic [63:0] old,
                                               input logic [31:0] v, input int n,
                                               input logic hi);
        if (hi)
            return {merge_bytes(old[63:32], v, n), old[31:0]};
        return {old[63:32], merge_bytes(old[31:0], v, n)};
    endfunction

    task automatic shadow_reset();
        m_dev_feat = '0; m_magic = 32'h7472_6976; m_version = 32'd2;
        m_dev_id = 32'd2; m_vendor = '0; m_capacity = '0;
        m_dev_fsel = '0; m_drv_fsel = '0; m_qsel = '0; m_irq_status = '0;
        m_status = '0; m_drv_feat = '0; m_desc = '0; m_avail = '0; m_used = '0;
        m_qsize = '0; m_qready = 1'b0; m_irq = 1'b0;
    endtask

    // Computes the outcome of one transaction and advances the shadow state.
    function automatic vmmio_result_t register_outcome(input vmmio_item_t it);
        vmmio_result_t r;
        int            n;
        logic [31:0]   v, setb, sv;
        logic          qok;
        int            c;
        r = '0;
        n = (it.access_bytes == 0 || it.access_bytes > 4) ? 4 : int'(it.access_bytes);
        v = it.write_value & len_mask(n);
        qok = m_qsel < NQ;
        if (it.op == OP_READ) begin
            r.read_hit = 1'b1;
            if (it.reg_offset >= CFG_SPACE_BASE) begin
                c = int'(it.reg_offset - CFG_SPACE_BASE);
                if (c + n > 8)
                    r.read_hit = 1'b0;
                else
                    r.read_value = 32'(m_capacity >> (8 * c)) & len_mask(n);
            end else begin
                case (it.reg_offset)
                    OFF_MAGIC:      r.read_value = m_magic;
                    OFF_VERSION:    r.read_value = m_version;
                    OFF_DEVICE_ID:  r.read_value = m_dev_id;
                    OFF_VENDOR_ID:  r.read_value = m_vendor;
                    OFF_DEV_FEAT:   r.read_value = (m_dev_fsel == 0) ? m_dev_feat[31:0] :
                                        (m_dev_fsel == 1) ? m_dev_feat[63:32] : 32'd0;
                    OFF_QMAX:       r.read_value = qok ? QMAX : 0;
                    OFF_QREADY:     r.read_value = qok ? {31'd0, m_qready} : 32'hffff_ffff;
                    OFF_IRQ_STATUS: r.read_value = m_irq_status;
                    OFF_STATUS:     r.read_value = m_status;
                    default:        r.read_hit = 1'b0;
                endcase
            end
        end else if (it.op == OP_WRITE) begin
            case (it.reg_offset)
                OFF_DEV_FSEL: begin
                    m_dev_fsel = merge_bytes(m_dev_fsel, v, n);
                    r.write_applied = 1'b1;
                end
                OFF_DRV_FEAT: if (m_drv_fsel < 2) begin
                    m_drv_feat = merge_word(m_drv_feat, v, n, m_drv_fsel == 1);
                    r.write_applied = 1'b1;
                end
                OFF_DRV_FSEL: begin
                    m_drv_fsel = merge_bytes(m_drv_fsel, v, n);
                    r.write_applied = 1'b1;
                end
                OFF_QSEL: begin
                    m_qsel = merge_bytes(m_qsel, v, n);
                    r.write_applied = 1'b1;
                end
                OFF_QSIZE: if (qok) begin
                    m_qsize = 16'(merge_bytes({16'd0, m_qsize}, v, (n > 2) ? 2 : n));
                    r.write_applied = 1'b1;
                end
                OFF_QREADY: if (qok) begin
                    m_qready = v[0];
                    r.write_applied = 1'b1;
                end
                OFF_NOTIFY: begin
                    r.notify_valid = 1'b1;
                    r.notify_queue = v[15:0];
                    r.notify_bad_queue = v[15:0] >= NQ;
                end
                OFF_IRQ_ACK: if ((v & IRQ_ACK_MASK) != 0) begin
                    r.irq_changed = m_irq;
                    m_irq = 1'b0;
                    m_irq_status &= ~v;
                    r.write_applied = 1'b1;
                end
                OFF_STATUS: begin
                    // A write that sets no new bit clears the written status bytes.
                    // Setting only the feature-check bit fails when the driver asked
                    // for more than the device offers.
                    setb = v & ~m_status;
                    if (setb == 0)
                        sv = 0;
                    else if (setb == DEV_STATUS_FEAT_BIT && (m_drv_feat & ~m_dev_feat) != 0)
                        sv = v & ~DEV_STATUS_FEAT_BIT;
                    else
                        sv = v;
                    m_status = merge_bytes(m_status, sv, n);
                    r.write_applied = 1'b1;
                end
                OFF_DESC_LO, OFF_DESC_HI: if (qok) begin
                    m_desc = merge_word(m_desc, v, n, it.reg_offset == OFF_DESC_HI);
                    r.write_applied = 1'b1;
                end
                OFF_AVAIL_LO, OFF_AVAIL_HI: if (qok) begin
                    m_avail = merge_word(m_avail, v, n, it.reg_offset == OFF_AVAIL_HI);
                    r.write_applied = 1'b1;
                end
                OFF_USED_LO, OFF_USED_HI: if (qok) begin
                    m_used = merge_word(m_used, v, n, it.reg_offset == OFF_USED_HI);
                    r.write_applied = 1'b1;
                end
                default: ;
            endcase
        end else if (it.op == OP_COMPLETE) begin
            m_irq_status |= 32'd1;
            r.irq_changed = !m_irq;
            m_irq = 1'b1;
        end
        r.irq_level = m_irq;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %h expected %h", cycles, what, got, want);
        mismatches++;
    endtask

    // Result checker: each strobed result is compared with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && done) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", result.read_value, 0);
            end else begin
                vmmio_result_t e;
                e = pending_results.pop_front();
                if (result.read_value !== e.read_value)
                    report_mismatch("read_value", result.read_value, e.read_value);
                if (result.read_hit !== e.read_hit)
                    report_mismatch("read_hit", result.read_hit, e.read_hit);
                if (result.write_applied !== e.write_applied)
                    report_mismatch("write_applied", result.write_applied, e.write_applied);
                if (result.notify_valid !== e.notify_valid)
                    report_mismatch("notify_valid", result.notify_valid, e.notify_valid);
                if (result.notify_queue !== e.notify_queue)
                    report_mismatch("notify_queue", result.notify_queue, e.notify_queue);
                if (result.notify_bad_queue !== e.notify_bad_queue)
                    report_mismatch("notify_bad_queue", result.notify_bad_queue,
                                    e.notify_bad_queue);
                if (result.irq_level !== e.irq_level)
                    report_mismatch("irq_level", result.irq_level, e.irq_level);
                if (result.irq_changed !== e.irq_changed)
                    report_mismatch("irq_changed", result.irq_changed, e.irq_changed);
            end
        end
    end

    // Watchdog: a hung block ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Burst/gap state for the sender.
    int burst_left;

    // Presents one transaction and holds it until the block takes it. The
    // prediction is made at the accepting edge so it sees every earlier item.
    // Start stays high within a burst and drops only for a gap.
    task automatic send_item(input vmmio_item_t it, input logic chk,
                             input vmmio_result_t want);
        vmmio_result_t p;
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy) @(posedge clk);
        p = register_outcome(it);
        if (chk && p !== want)
            report_mismatch("typed-in prediction", p[31:0], want[31:0]);
        pending_results.push_back(p);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [2:0] idx, input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_DEV_FEATURES: m_dev_feat = val;
            CFG_MAGIC:        m_magic    = val[31:0];
            CFG_VERSION:      m_version  = val[31:0];
            CFG_DEVICE_ID:    m_dev_id   = val[31:0];
            CFG_VENDOR_ID:    m_vendor   = val[31:0];
            CFG_CAPACITY:     m_capacity = val;
            default: ;
        endcase
    endtask

    task automatic load_all_config(input logic [63:0] a, input logic [63:0] b);
        write_config(CFG_DEV_FEATURES, a);
        write_config(CFG_MAGIC, b);
        write_config(CFG_VERSION, ~b);
        write_config(CFG_DEVICE_ID, a >> 32);
        write_config(CFG_VENDOR_ID, a ^ b);
        write_config(CFG_CAPACITY, b ^ {a[31:0], a[63:32]});
        cfg_we <= 1'b0;
    endtask

    typedef struct {
        vmmio_item_t   it;
        logic          chk;
        vmmio_result_t want;
    } stim_row_t;

    function automatic vmmio_item_t mk(input logic [1:0] op, input logic [11:0] off,
                                       input logic [31:0] v, input logic [2:0] n);
        vmmio_item_t it;
        it.op = op; it.reg_offset = off; it.write_value = v; it.access_bytes = n;
        return it;
    endfunction

    function automatic vmmio_result_t rd(input logic [31:0] v, input logic hit,
                                         input logic irq);
        vmmio_result_t r;
        r = '0; r.read_value = v; r.read_hit = hit; r.irq_level = irq;
        return r;
    endfunction

    // Offsets that are decoded, drawn with equal weight.
    logic [11:0] known_offsets[] = '{OFF_MAGIC, OFF_VERSION, OFF_DEVICE_ID, OFF_VENDOR_ID,
        OFF_DEV_FEAT, OFF_DEV_FSEL, OFF_DRV_FEAT, OFF_DRV_FSEL, OFF_QSEL, OFF_QMAX,
        OFF_QSIZE, OFF_QREADY, OFF_NOTIFY, OFF_IRQ_STATUS, OFF_IRQ_ACK, OFF_STATUS,
        OFF_DESC_LO, OFF_DESC_HI, OFF_AVAIL_LO, OFF_AVAIL_HI, OFF_USED_LO, OFF_USED_HI};

    function automatic vmmio_item_t random_item();
        vmmio_item_t it;
        int          k;
        it.op = ($urandom_range(0, 19) == 0) ? 2'($urandom_range(2, 3))
                                             : 2'($urandom_range(0, 1));
        k = $urandom_range(0, 9);
        if (k < 7)
            it.reg_offset = known_offsets[$urandom_range(0, known_offsets.size() - 1)];
        else if (k < 9)
            it.reg_offset = CFG_SPACE_BASE + 12'($urandom_range(0, 9));
        else
            it.reg_offset = 12'($urandom);
        // Some write values are kept small so selects and queue index can stay live.
        case ($urandom_range(0, 3))
            0:       it.write_value = $urandom_range(0, 3);
            1:       it.write_value = 32'd1 << $urandom_range(0, 31);
            default: it.write_value = $urandom;
        endcase
        it.access_bytes = 3'($urandom_range(0, 7));
        return it;
    endfunction

    initial
    begin
        stim_row_t rows[$];
        cycles = 0; mismatches = 0; burst_left = 0;
        rst_n = 1'b0; start = 1'b0; item = '0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        shadow_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: identity reads after reset, every operation, the
        // feature-select repair, the bad notify, the status reset and the
        // failed feature check, config space bounds and the unused op.
        rows.push_back('{mk(OP_READ, OFF_MAGIC, 0, 4), 1, rd(32'h7472_6976, 1, 0)});
        rows.push_back('{mk(OP_READ, OFF_VERSION, 0, 4), 1, rd(2, 1, 0)});
        rows.push_back('{mk(OP_READ, OFF_DEVICE_ID, 0, 4), 1, rd(2, 1, 0)});
        rows.push_back('{mk(OP_READ, OFF_QMAX, 0, 4), 1, rd(QMAX, 1, 0)});
        rows.push_back('{mk(OP_READ, 12'hfff, 0, 4), 1, rd(0, 0, 0)});
        rows.push_back('{mk(OP_READ, 12'h105, 0, 4), 1, rd(0, 0, 0)});
        rows.push_back('{mk(OP_WRITE, OFF_DEV_FSEL, 32'hffff_ffff, 0), 0, '0});
        rows.push_back('{mk(OP_READ, OFF_DEV_FEAT, 0, 4), 1, rd(0, 1, 0)});
        rows.push_back('{mk(OP_WRITE, OFF_DRV_FSEL, 2, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_DRV_FEAT, 32'hffff_ffff, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_DRV_FSEL, 0, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_DRV_FEAT, 32'h8000_0001, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_STATUS, 32'h7, 1), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_STATUS, 32'hf, 1), 0, '0});
        rows.push_back('{mk(OP_READ, OFF_STATUS, 0, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_STATUS, 0, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_NOTIFY, 32'h0000_ffff, 2), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_NOTIFY, 0, 2), 0, '0});
        rows.push_back('{mk(OP_COMPLETE, 0, 0, 4), 0, '0});
        rows.push_back('{mk(OP_READ, OFF_IRQ_STATUS, 0, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_IRQ_ACK, 32'h4, 4), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_IRQ_ACK, 32'hffff_ffff, 3), 0, '0});
        rows.push_back('{mk(OP_WRITE, OFF_QSEL, 5, 1), 0, '0});
        rows.push_back('{mk(OP_READ, OFF_QREADY, 0, 4), 1, rd(32'hffff_ffff, 1, 0)});
        rows.push_back('{mk(2'd3, OFF_QSIZE, 32'hffff_ffff, 7), 0, '0});
        foreach (rows[i])
            send_item(rows[i].it, rows[i].chk, rows[i].want);
        drain_results();

        // Random phases under several device configurations, extremes first.
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: load_all_config('0, '0);
                1: load_all_config('1, '1);
                default: load_all_config({$urandom, $urandom}, {$urandom, $urandom});
            endcase
            for (int i = 0; i < 285; i++) begin
                send_item(random_item(), 1'b0, '0);
                // Queue select wanders out of range; pull it back now and then.
                if ($urandom_range(0, 29) == 0)
                    send_item(mk(OP_WRITE, OFF_QSEL, 0, 4), 1'b0, '0);
                if (i == 140)
                    drain_results();
            end
            drain_results();
        end

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
hdl/vmmio_pkg.sv
hdl/vmmio_ctrl.sv
hdl/vmmio_dp.sv
hdl/virtio_mmio_register_block.sv
hdl/vmmio_checker.sv
test/virtio_mmio_register_block_tb.sv
